/* hdl/osr_pkg.sv */
package osr_pkg;

   // Default store depth
   localparam int unsigned OSR_CAPACITY = 1024;

   // Field widths
   localparam int unsigned KEY_W    = 32;
   localparam int unsigned POS_W    = 10;
   localparam int unsigned STATUS_W = 2;

   // Input kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // Commands broadcast to every cell of the chain
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [KEY_W-1:0] operand;   // key to insert or rank to remove
   } osr_cmd_type;

endpackage

/* hdl/osr_cell.sv */
module osr_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 11
) (
   input  logic                       clock,
   input  osr_pkg::osr_cmd_type       cmd,
   input  logic [CNT_W-1:0]           count,
   input  logic [osr_pkg::KEY_W-1:0]  left_key,
   input  logic [osr_pkg::KEY_W-1:0]  right_key,
   input  logic                       prev_ge,
   output logic [osr_pkg::KEY_W-1:0]  key,
   output logic                       gt,
   output logic                       ge
);
   import osr_pkg::*;

   localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(INDEX);
   localparam logic [KEY_W-1:0] RANK_IDX = KEY_W'(INDEX);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             occupied;

   assign occupied = CELL_IDX < count;
   assign gt       = occupied && ($signed(key_ff) >  $signed(cmd.operand));
   assign ge       = occupied && ($signed(key_ff) >= $signed(cmd.operand));
   assign key      = key_ff;

   // Insert: hold where the key is not less, take the new key at the first
   // cell that is, shift right beyond it. Remove: close the gap from the right.
   always_comb begin
      key_in = key_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            if (!ge) begin
               key_in = prev_ge ? cmd.operand : left_key;
            end
         end
         OP_REMOVE: begin
            if (RANK_IDX >= cmd.operand) begin
               key_in = right_key;
            end
         end
         default: key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

/* hdl/osr_pos_enc.sv */
module osr_pos_enc #(
   parameter int unsigned CAPACITY = 1024,
   parameter int unsigned IDX_W    = 10
) (
   input  logic [CAPACITY-1:0] gt,
   output logic [IDX_W-1:0]    idx
);
   import osr_pkg::*;

   // The greater flags form a run of ones from cell 0; mark the first zero
   // and fold its index into the result.
   always_comb begin
      logic bnd;
      idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         bnd = !gt[i] && ((i == 0) || gt[(i == 0) ? 0 : i - 1]);
         idx = idx | (bnd ? IDX_W'(i) : '0);
      end
   end

endmodule

/* hdl/order_statistic_rank_store_unit.sv */
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata: value[31:0]; tuser: kind
// rsp       out  rsp_tvalid/rsp_tready  tdata: position[9:0], status[11:10]
//
// An item is taken in idle and worked in the cell chain the cycle after.
// Insert: accept, compare and shift in every cell, encode the position;
// remove: accept, close the gap, no result; refusals: accept, result.
// The position encoder over all cells works in the encode state.
// Reset clears the sequencer, the fill count and the result flag; the cell
// keys need no clearing.
// A result waiting in the output register does not stop the next accept;
// only a new result that finds the register still occupied holds the unit.
module order_statistic_rank_store_unit #(
   parameter int unsigned CAPACITY = osr_pkg::OSR_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // position[9:0], status[11:10], zero[15:12]
);
   import osr_pkg::*;

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned IDX_W = $clog2(CAPACITY);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_ENC  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                kind_ff;
   logic [KEY_W-1:0]    value_ff;
   logic [CAPACITY-1:0] gt_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   osr_cmd_type         cmd;
   logic [KEY_W-1:0]    cell_key [CAPACITY];
   logic [CAPACITY-1:0] cell_gt;
   logic [CAPACITY-1:0] cell_ge;
   logic [IDX_W-1:0]    enc_idx;
   logic [POS_W+IDX_W-1:0] pos_ext;
   logic                full;
   logic                rank_ok;
   logic                slot_free;
   logic                rsp_load;
   logic                req_xfer;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign rank_ok    = value_ff < KEY_W'(count_ff);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Chain of key cells, each looking only at its neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      osr_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .left_key  ((i == 0) ? '0 : cell_key[(i == 0) ? 0 : i - 1]),
         .right_key ((i == CAPACITY - 1) ? '0 : cell_key[(i == CAPACITY - 1) ? i : i + 1]),
         .prev_ge   ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i - 1]),
         .key       (cell_key[i]),
         .gt        (cell_gt[i]),
         .ge        (cell_ge[i])
      );
   end

   osr_pos_enc #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_pos_enc (
      .gt  (gt_ff),
      .idx (enc_idx)
   );

   // Report the position modulo the field width
   assign pos_ext = {{POS_W{1'b0}}, enc_idx};

   // Sequencer: decide the chain command and the result for this cycle
   always_comb begin
      cmd.op        = OP_HOLD;
      cmd.operand   = value_ff;
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_load      = 1'b0;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (kind_ff == KIND_INSERT) begin
               if (!full) begin
                  cmd.op   = OP_INSERT;
                  count_in = count_ff + 1'b1;
                  state_in = S_ENC;
               end else if (slot_free) begin
                  rsp_load      = 1'b1;
                  rsp_pos_in    = '0;
                  rsp_status_in = ST_FULL;
                  state_in      = S_IDLE;
               end
            end else begin
               if (rank_ok) begin
                  cmd.op   = OP_REMOVE;
                  count_in = count_ff - 1'b1;
                  state_in = S_IDLE;
               end else if (slot_free) begin
                  rsp_load      = 1'b1;
                  rsp_pos_in    = '0;
                  rsp_status_in = ST_RANGE;
                  state_in      = S_IDLE;
               end
            end
         end
         S_ENC: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_pos_in    = pos_ext[POS_W-1:0];
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold a result until transfer, reload in the same cycle it leaves
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture the item, the greater flags and the result
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff  <= req_tuser;
         value_ff <= req_tdata;
      end
      if (state_ff == S_EXEC) begin
         gt_ff <= cell_gt;
      end
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_status_ff, rsp_pos_ff};

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && kind_ff == KIND_INSERT && !full)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted insert did not grow the store");

   a_enc_follows_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENC && $past(state_ff) != S_ENC) |-> $past(state_ff) == S_EXEC)
      else $error("position encode entered without a chain update");

   a_refusal_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_pos_ff == '0)
      else $error("refused item carries a non-zero position");
`endif

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import osr_pkg::*;

   // Store depth under test: the block's own default
   localparam int unsigned CAP = OSR_CAPACITY;
   // Cycles that may still pass after the last result while a remove drains
   localparam int unsigned TAIL_CYCLES = 10;
   localparam int unsigned DRAIN_LIMIT = 5000;
   localparam int unsigned RANDOM_ITEMS = 620;
   localparam int unsigned DIRECTED_ROWS = 20;

   typedef struct packed {
      logic [POS_W-1:0]    position;
      logic [STATUS_W-1:0] status;
   } rank_rsp_type;

   // One row of the directed plan; typed_in rows carry a literal expectation
   typedef struct packed {
      logic                kind;
      logic [KEY_W-1:0]    value;
      logic                typed_in;
      logic [POS_W-1:0]    position;
      logic [STATUS_W-1:0] status;
   } plan_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // value[31:0]
   logic        req_tuser  = 1'b0; // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // position[9:0], status[11:10], zero[15:12]

   // Shadow copy of the store: keys from greatest to least
   logic signed [KEY_W-1:0] shadow_keys [CAP];
   int unsigned             shadow_fill;

   rank_rsp_type rsp_pending [$];
   int unsigned  mismatches = 0;
   bit           steady     = 1'b0; // set while neither side may idle

   int unsigned n_insert = 0, n_remove = 0, n_full = 0, n_range = 0, peak_fill = 0;

   plan_row_type plan [DIRECTED_ROWS] = '{
      // remove from the empty store is out of range
      '{KIND_REMOVE, 32'h0000_0000, 1'b1, 10'd0, ST_RANGE},
      // first keys: the first two land at the top, the most negative at the bottom
      '{KIND_INSERT, 32'h0000_0000, 1'b1, 10'd0, ST_OK},
      '{KIND_INSERT, 32'h7FFF_FFFF, 1'b1, 10'd0, ST_OK},
      '{KIND_INSERT, 32'h8000_0000, 1'b0, 10'd0, ST_OK},
      // equal keys follow the stored equals
      '{KIND_INSERT, 32'h0000_0000, 1'b0, 10'd0, ST_OK},
      '{KIND_INSERT, 32'h0000_0000, 1'b0, 10'd0, ST_OK},
      '{KIND_INSERT, 32'hFFFF_FFFF, 1'b0, 10'd0, ST_OK},
      '{KIND_INSERT, 32'h0000_0001, 1'b0, 10'd0, ST_OK},
      // negative ranks, and the rank equal to the count, are refused
      '{KIND_REMOVE, 32'hFFFF_FFFF, 1'b1, 10'd0, ST_RANGE},
      '{KIND_REMOVE, 32'h8000_0000, 1'b1, 10'd0, ST_RANGE},
      '{KIND_REMOVE, 32'h0000_0007, 1'b1, 10'd0, ST_RANGE},
      // last, first and middle removes give no result
      '{KIND_REMOVE, 32'h0000_0006, 1'b0, 10'd0, ST_OK},
      '{KIND_REMOVE, 32'h0000_0000, 1'b0, 10'd0, ST_OK},
      '{KIND_REMOVE, 32'h0000_0002, 1'b0, 10'd0, ST_OK},
      '{KIND_INSERT, 32'h7FFF_FFFF, 1'b0, 10'd0, ST_OK},
      '{KIND_INSERT, 32'h8000_0000, 1'b0, 10'd0, ST_OK},
      '{KIND_INSERT, 32'h5555_5555, 1'b0, 10'd0, ST_OK},
      '{KIND_INSERT, 32'hAAAA_AAAA, 1'b0, 10'd0, ST_OK},
      '{KIND_REMOVE, 32'h0000_0001, 1'b0, 10'd0, ST_OK},
      '{KIND_REMOVE, 32'h7FFF_FFFF, 1'b1, 10'd0, ST_RANGE}
   };

   order_statistic_rank_store_unit #(
      .CAPACITY (CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop should the block hang
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // Work out the result of one accepted item and advance the shadow store
   task automatic rank_store_apply(input logic kind, input logic [KEY_W-1:0] value,
                                   output bit has_rsp, output rank_rsp_type rsp);
      logic signed [KEY_W-1:0] key;
      int unsigned greater;
      int unsigned slot;
      key     = $signed(value);
      has_rsp = 1'b1;
      rsp     = '{position: '0, status: ST_OK};
      if (kind == KIND_INSERT) begin
         n_insert++;
         if (shadow_fill >= CAP) begin
            rsp.status = ST_FULL;
            n_full++;
         end else begin
            greater = 0;
            while (greater < shadow_fill && shadow_keys[greater] > key) greater++;
            slot = greater;
            // place the new key behind any equals already held
            while (slot < shadow_fill && shadow_keys[slot] == key) slot++;
            for (int unsigned i = shadow_fill; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[slot] = key;
            shadow_fill++;
            if (shadow_fill > peak_fill) peak_fill = shadow_fill;
            rsp.position = greater[POS_W-1:0];
         end
      end else begin
         n_remove++;
         if (value >= shadow_fill) begin
            rsp.status = ST_RANGE;
            n_range++;
         end else begin
            for (int unsigned i = value; i + 1 < shadow_fill; i++) shadow_keys[i] = shadow_keys[i+1];
            shadow_fill--;
            has_rsp = 1'b0;
         end
      end
   endtask

   // Present one item, hold it until the transfer, then record its expectation
   task automatic transfer_item(input logic kind, input logic [KEY_W-1:0] value,
                                input logic typed_in, input rank_rsp_type typed_rsp);
      bit           has_rsp;
      rank_rsp_type rsp;
      req_tuser  <= kind;
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rank_store_apply(kind, value, has_rsp, rsp);
      if (typed_in) rsp_pending.push_back(typed_rsp);
      else if (has_rsp) rsp_pending.push_back(rsp);
   endtask

   // Idle the sender for a random run of cycles, never while steady
   task automatic sender_gap();
      while (!steady && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Hold the sender until every outstanding result has been taken or the drain limit runs out
   task automatic wait_for_results();
      int unsigned guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rsp_pending.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 3) return KEY_W'($signed($urandom_range(16)) - 8);
      if (r < 5 && shadow_fill > 0) return shadow_keys[$urandom_range(shadow_fill - 1)];
      if (r == 5) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return $urandom;
   endfunction

   function automatic logic [KEY_W-1:0] pick_rank();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 7 && shadow_fill > 0) return $urandom_range(shadow_fill - 1);
      if (r == 7) return shadow_fill;
      if (r == 8) return $urandom;
      return $urandom_range(3);
   endfunction

   // Result side: check each transfer against the oldest expectation
   always @(posedge clock) begin
      rank_rsp_type got;
      rank_rsp_type want;
      got.position = rsp_tdata[POS_W-1:0];
      got.status   = rsp_tdata[POS_W+STATUS_W-1:POS_W];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_pending.size() == 0) begin
            flag_mismatch($sformatf("result with nothing pending: position %0d status %0d",
                                    got.position, got.status));
         end else begin
            want = rsp_pending.pop_front();
            if (got.position !== want.position)
               flag_mismatch($sformatf("position expected %0d got %0d",
                                       want.position, got.position));
            if (got.status !== want.status)
               flag_mismatch($sformatf("status expected %0d got %0d",
                                       want.status, got.status));
         end
      end
      // stall at random about 20 percent of the time, except during the steady stretch
      rsp_tready <= steady || ($urandom_range(99) >= 20);
   end

   initial begin
      int unsigned guard;
      logic        kind;
      shadow_fill = 0;

      // Hold reset from the start, then release it once
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed plan
      foreach (plan[i]) begin
         sender_gap();
         transfer_item(plan[i].kind, plan[i].value, plan[i].typed_in,
                       '{position: plan[i].position, status: plan[i].status});
      end
      wait_for_results();

      // Random mix, leaning towards inserts so the store grows
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 250 && i < 400);
         if (i == 500) wait_for_results();
         sender_gap();
         kind = ($urandom_range(99) < 60) ? KIND_INSERT : KIND_REMOVE;
         transfer_item(kind, (kind == KIND_INSERT) ? pick_key() : pick_rank(), 1'b0, '0);
      end
      steady = 1'b0;

      // bottom rank of the store, then the first rank past it
      transfer_item(KIND_REMOVE, shadow_fill - 1, 1'b0, '0);
      transfer_item(KIND_REMOVE, shadow_fill, 1'b0, '0);

      // Drain the outstanding results, then allow for a remove still in flight
      req_tvalid <= 1'b0;
      guard = 0;
      while (rsp_pending.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (rsp_pending.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", rsp_pending.size()));

      $display("covered %0d inserts (%0d refused as full), %0d removes (%0d out of range)",
               n_insert, n_full, n_remove, n_range);
      $display("store reached %0d of %0d entries; %0d mismatches", peak_fill, CAP, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* order_statistic_rank_store_unit.f */
hdl/osr_pkg.sv
hdl/osr_cell.sv
hdl/osr_pos_enc.sv
hdl/order_statistic_rank_store_unit.sv
verif/testbench.sv
